>>> hdl/nps_pkg.sv
// Shared types, codes and the microprogram for the nearest point search core.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  // Operation codes carried in the op field of a command word.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  // Status codes returned in a result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Jump conditions that a control word can test.
  typedef enum logic [3:0] {
    C_ALWAYS    = 4'd0,
    C_ACCEPT    = 4'd1,
    C_OP_QUERY  = 4'd2,
    C_OP_APPEND = 4'd3,
    C_OP_RSVD   = 4'd4,
    C_FULL      = 4'd5,
    C_EMPTY     = 4'd6,
    C_LAST      = 4'd7,
    C_PIPE_IDLE = 4'd8,
    C_OUT_FREE  = 4'd9
  } cond_t;

  typedef logic [3:0] upc_t;

  // Step addresses of the microprogram.
  localparam upc_t UPC_FETCH     = 4'd0;
  localparam upc_t UPC_DEC_QUERY = 4'd1;
  localparam upc_t UPC_DEC_APP   = 4'd2;
  localparam upc_t UPC_DEC_RSVD  = 4'd3;
  localparam upc_t UPC_CLEAR     = 4'd4;
  localparam upc_t UPC_APPEND    = 4'd5;
  localparam upc_t UPC_WRITE     = 4'd6;
  localparam upc_t UPC_RPT_FULL  = 4'd7;
  localparam upc_t UPC_QUERY     = 4'd8;
  localparam upc_t UPC_SCAN      = 4'd9;
  localparam upc_t UPC_DRAIN     = 4'd10;
  localparam upc_t UPC_RPT_OK    = 4'd11;
  localparam upc_t UPC_RPT_EMPTY = 4'd12;

  // One control word. When the condition holds the sequencer jumps to target;
  // otherwise it stays on the step if alt_self is set, else it falls through.
  typedef struct packed {
    logic    in_ready;
    logic    cnt_clear;
    logic    mem_write;
    logic    cnt_inc;
    logic    scan_init;
    logic    scan_issue;
    logic    out_load;
    status_t out_status;
    cond_t   cond;
    logic    alt_self;
    upc_t    target;
  } ctl_t;

  // Status flags that the datapath reports back to the sequencer.
  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic full;
    logic empty;
    logic last;
    logic pipe_idle;
    logic out_free;
  } flags_t;

  // The microprogram ROM.
  function automatic ctl_t ucode_rom(input upc_t addr);
    ctl_t w;
    w = '0;
    w.cond = C_ALWAYS;
    w.target = UPC_FETCH;
    unique case (addr)
      UPC_FETCH: begin
        w.in_ready = 1'b1;
        w.cond = C_ACCEPT;
        w.alt_self = 1'b1;
        w.target = UPC_DEC_QUERY;
      end
      UPC_DEC_QUERY: begin
        w.cond = C_OP_QUERY;
        w.target = UPC_QUERY;
      end
      UPC_DEC_APP: begin
        w.cond = C_OP_APPEND;
        w.target = UPC_APPEND;
      end
      UPC_DEC_RSVD: begin
        w.cond = C_OP_RSVD;
        w.target = UPC_FETCH;
      end
      UPC_CLEAR: begin
        w.cnt_clear = 1'b1;
      end
      UPC_APPEND: begin
        w.cond = C_FULL;
        w.target = UPC_RPT_FULL;
      end
      UPC_WRITE: begin
        w.mem_write = 1'b1;
        w.cnt_inc = 1'b1;
      end
      UPC_RPT_FULL: begin
        w.out_load = 1'b1;
        w.out_status = ST_FULL;
        w.cond = C_OUT_FREE;
        w.alt_self = 1'b1;
      end
      UPC_QUERY: begin
        w.scan_init = 1'b1;
        w.cond = C_EMPTY;
        w.target = UPC_RPT_EMPTY;
      end
      UPC_SCAN: begin
        w.scan_issue = 1'b1;
        w.cond = C_LAST;
        w.alt_self = 1'b1;
        w.target = UPC_DRAIN;
      end
      UPC_DRAIN: begin
        w.cond = C_PIPE_IDLE;
        w.alt_self = 1'b1;
        w.target = UPC_RPT_OK;
      end
      UPC_RPT_OK: begin
        w.out_load = 1'b1;
        w.out_status = ST_OK;
        w.cond = C_OUT_FREE;
        w.alt_self = 1'b1;
      end
      UPC_RPT_EMPTY: begin
        w.out_load = 1'b1;
        w.out_status = ST_EMPTY;
        w.cond = C_OUT_FREE;
        w.alt_self = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nps_if.sv
// Valid/ready channel interfaces for command words and result words.
// Self-contained; the core and its neighbors connect through these.
`timescale 1ns / 1ps
`default_nettype none

// Command channel: operation and one 3D point in signed Q8.8.
interface nps_cmd_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, op, point_x, point_y, point_z, input ready);
  modport sink (input valid, op, point_x, point_y, point_z, output ready);
endinterface

// Result channel: nearest index, its squared distance and a status code.
interface nps_result_if #(
  parameter int IDX_W  = 10,
  parameter int DIST_W = 34
);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  nearest_index;
  logic [DIST_W-1:0] min_sq_distance;
  logic [1:0]        status;

  modport source (output valid, nearest_index, min_sq_distance, status, input ready);
  modport sink (input valid, nearest_index, min_sq_distance, status, output ready);
endinterface

`default_nettype wire

>>> hdl/nps_useq.sv
// Microcoded sequencer: step counter, control word ROM and jump logic.
// Depends on nps_pkg for the control word, flags and the microprogram.
`timescale 1ns / 1ps
`default_nettype none

module nps_useq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire nps_pkg::flags_t flags,
  output nps_pkg::ctl_t        ctl,
  output logic                 take
);
  import nps_pkg::*;

  upc_t upc;
  upc_t upc_next;

  // Fetch the control word for the current step.
  assign ctl = ucode_rom(upc);

  // Evaluate the condition that the control word selects.
  always_comb begin
    unique case (ctl.cond)
      C_ALWAYS:    take = 1'b1;
      C_ACCEPT:    take = flags.in_valid;
      C_OP_QUERY:  take = (flags.op == OP_QUERY);
      C_OP_APPEND: take = (flags.op == OP_APPEND);
      C_OP_RSVD:   take = (flags.op == OP_RSVD);
      C_FULL:      take = flags.full;
      C_EMPTY:     take = flags.empty;
      C_LAST:      take = flags.last;
      C_PIPE_IDLE: take = flags.pipe_idle;
      C_OUT_FREE:  take = flags.out_free;
      default:     take = 1'b0;
    endcase
  end

  // Next step: jump, hold, or fall through.
  always_comb begin
    if (take) begin
      upc_next = ctl.target;
    end else if (ctl.alt_self) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 4'd1;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // A report step that cannot load the result register must not move on.
  a_report_holds: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && !take) |=> (upc == $past(upc)))
    else $error("report step left without loading the result");

  // A point is only written while the store has room.
  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    ctl.mem_write |-> !flags.full)
    else $error("model store written while full");

endmodule

`default_nettype wire

>>> hdl/nps_datapath.sv
// Datapath: command latch, model point memory, distance pipeline, best
// tracker and result register. Depends on nps_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module nps_datapath #(
  parameter int MODEL_DEPTH = 1024,
  parameter int COORD_BITS  = 16,
  parameter int IDX_W       = 10,
  parameter int CNT_W       = 11,
  parameter int DIST_W      = 34
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire nps_pkg::ctl_t   ctl,
  input  wire logic            take,
  output nps_pkg::flags_t      flags,
  nps_cmd_if.sink              cmd,
  nps_result_if.source         result
);
  import nps_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SQ_W = 2 * CW;

  // Latched command word.
  op_t                  op_r;
  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;
  logic signed [CW-1:0] qz;
  logic                 accept;

  // Store fill count and scan address.
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_addr;

  // Model point memory, one {z, y, x} entry per point.
  logic [3*CW-1:0] mem [MODEL_DEPTH];

  // Distance pipeline.
  logic                 s1_valid;
  logic [IDX_W-1:0]     s1_idx;
  logic [3*CW-1:0]      s1_data;
  logic                 s2_valid;
  logic [IDX_W-1:0]     s2_idx;
  logic signed [CW:0]   s2_dx;
  logic signed [CW:0]   s2_dy;
  logic signed [CW:0]   s2_dz;
  logic signed [SQ_W+1:0] prod_x;
  logic signed [SQ_W+1:0] prod_y;
  logic signed [SQ_W+1:0] prod_z;
  logic                 s3_valid;
  logic [IDX_W-1:0]     s3_idx;
  logic [SQ_W-1:0]      s3_sqx;
  logic [SQ_W-1:0]      s3_sqy;
  logic [SQ_W-1:0]      s3_sqz;
  logic                 s4_valid;
  logic [IDX_W-1:0]     s4_idx;
  logic [DIST_W-1:0]    s4_sum;

  // Best candidate so far.
  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;

  // Result register.
  logic              out_valid;
  logic              out_load;
  logic [IDX_W-1:0]  out_idx;
  logic [DIST_W-1:0] out_dist;
  status_t           out_st;

  // Command handshake and latch.
  assign cmd.ready = ctl.in_ready;
  assign accept = cmd.valid & ctl.in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_t'(cmd.op);
      qx <= cmd.point_x;
      qy <= cmd.point_y;
      qz <= cmd.point_z;
    end
  end

  // Fill count of the model store.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_clear) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + 1'b1;
    end
  end

  // Memory write at the fill count and registered read at the scan address.
  always_ff @(posedge clk) begin
    if (ctl.mem_write) begin
      mem[count[IDX_W-1:0]] <= {qz, qy, qx};
    end
    if (ctl.scan_issue) begin
      s1_data <= mem[scan_addr];
    end
  end

  // Scan address walks the store one entry per cycle.
  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      scan_addr <= '0;
    end else if (ctl.scan_issue) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.scan_issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Coordinate differences, one extra bit so they never overflow.
  always_ff @(posedge clk) begin
    s1_idx <= scan_addr;
    s2_idx <= s1_idx;
    s2_dx <= {qx[CW-1], qx} - {s1_data[CW-1], s1_data[CW-1:0]};
    s2_dy <= {qy[CW-1], qy} - {s1_data[2*CW-1], s1_data[2*CW-1:CW]};
    s2_dz <= {qz[CW-1], qz} - {s1_data[3*CW-1], s1_data[3*CW-1:2*CW]};
  end

  // Squares; each fits in 2*COORD_BITS unsigned bits.
  assign prod_x = s2_dx * s2_dx;
  assign prod_y = s2_dy * s2_dy;
  assign prod_z = s2_dz * s2_dz;

  always_ff @(posedge clk) begin
    s3_idx <= s2_idx;
    s3_sqx <= prod_x[SQ_W-1:0];
    s3_sqy <= prod_y[SQ_W-1:0];
    s3_sqz <= prod_z[SQ_W-1:0];
  end

  // Sum of the three squares.
  always_ff @(posedge clk) begin
    s4_idx <= s3_idx;
    s4_sum <= DIST_W'(s3_sqx) + DIST_W'(s3_sqy) + DIST_W'(s3_sqz);
  end

  // Keep the first point with the smallest distance; entry 0 always seeds it.
  always_ff @(posedge clk) begin
    if (s4_valid && ((s4_idx == '0) || (s4_sum < best_dist))) begin
      best_idx <= s4_idx;
      best_dist <= s4_sum;
    end
  end

  // Result register, freed when the sink takes the word.
  assign out_load = ctl.out_load & take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_st <= ctl.out_status;
      if (ctl.out_status == ST_OK) begin
        out_idx <= best_idx;
        out_dist <= best_dist;
      end else begin
        out_idx <= '0;
        out_dist <= '0;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.nearest_index = out_idx;
  assign result.min_sq_distance = out_dist;
  assign result.status = out_st;

  // Flags back to the sequencer.
  assign flags.in_valid = cmd.valid;
  assign flags.op = op_r;
  assign flags.full = (count == CNT_W'(MODEL_DEPTH));
  assign flags.empty = (count == '0);
  assign flags.last = (CNT_W'(scan_addr) == (count - 1'b1));
  assign flags.pipe_idle = ~(s1_valid | s2_valid | s3_valid | s4_valid);
  assign flags.out_free = ~out_valid | result.ready;

  // A query result is only taken once the distance pipeline has drained.
  a_ok_after_drain: assert property (@(posedge clk) disable iff (rst)
    (out_load && (ctl.out_status == ST_OK)) |-> flags.pipe_idle)
    else $error("query result loaded while distances are in flight");

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MODEL_DEPTH))
    else $error("fill count beyond store depth");

endmodule

`default_nettype wire

>>> hdl/nearest_point_search_core.sv
// Top level of the brute-force 3D nearest point search core.
// Depends on nps_pkg, nps_if (channels), nps_useq and nps_datapath.
//
//   Channel  Dir  Word                                      Accepted when
//   cmd      in   op, point_x, point_y, point_z             cmd.valid && cmd.ready
//   result   out  nearest_index, min_sq_distance, status    result.valid && result.ready
//
// In a query, the single read port of the point memory feeds one distance
// evaluation per cycle, and the pipeline drains before the result word is loaded.
// Reset (rst, synchronous) empties the store at once; there is no clearing pass.
// The next command word is accepted while a result word waits; a further result
// waits in its report step until the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_search_core #(
  parameter int MODEL_DEPTH = 1024,
  parameter int COORD_BITS  = 16
) (
  input wire logic     clk,
  input wire logic     rst,
  nps_cmd_if.sink      cmd,
  nps_result_if.source result
);
  import nps_pkg::*;

  localparam int IDX_W  = (MODEL_DEPTH > 1) ? $clog2(MODEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MODEL_DEPTH + 1);
  localparam int DIST_W = 2 * COORD_BITS + 2;

  ctl_t   ctl;
  flags_t flags;
  logic   take;

  // Sequencer that runs the microprogram.
  nps_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl),
    .take  (take)
  );

  // Datapath that carries out each control word.
  nps_datapath #(
    .MODEL_DEPTH (MODEL_DEPTH),
    .COORD_BITS  (COORD_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .DIST_W      (DIST_W)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .take   (take),
    .flags  (flags),
    .cmd    (cmd),
    .result (result)
  );

endmodule

`default_nettype wire
